// ----- hdl/dtsf_pkg.sv -----
// Package for the display text SysEx framer: frame byte constants, queue entry types,
// the Latin-1 folding table and the code point to display ASCII mapping.
// No dependencies.
`default_nettype none

package dtsf_pkg;

    // Frame bytes.
    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_MFR   = 8'h7D;
    localparam logic [7:0] SYX_DEV   = 8'h53;
    localparam logic [7:0] SYX_MODEL = 8'h47;
    localparam logic [7:0] SYX_CMD   = 8'h07;
    localparam logic [7:0] SYX_END   = 8'hF7;

    // Header is five fixed bytes and the line number.
    localparam int HDR_LEN   = 6;
    localparam int HDR_IDX_W = 3;

    // Display characters.
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_QUOTE = 7'h27;
    localparam logic [6:0] CH_DQUOT = 7'h22;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_QMARK = 7'h3F;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] cnt;
        logic [6:0] c0;
        logic [6:0] c1;
        logic [6:0] c2;
    } dtsf_chars_t;

    typedef struct packed {
        logic        hdr;
        logic [6:0]  line;
        dtsf_chars_t chars;
        logic        last;
    } dtsf_entry_t;

    function automatic dtsf_chars_t one_char(logic [6:0] c);
        dtsf_chars_t r;
        r.cnt = 2'd1;
        r.c0  = c;
        r.c1  = CH_SPACE;
        r.c2  = CH_SPACE;
        return r;
    endfunction

    function automatic dtsf_chars_t two_chars(logic [6:0] a, logic [6:0] b);
        dtsf_chars_t r;
        r.cnt = 2'd2;
        r.c0  = a;
        r.c1  = b;
        r.c2  = CH_SPACE;
        return r;
    endfunction

    // Folding of U+00C0..U+00FF, indexed by the low six bits.
    function automatic dtsf_chars_t fold_lookup(logic [5:0] idx);
        dtsf_chars_t r;
        case (idx) inside
            [6'd0:6'd5]:   r = one_char(7'h41);
            6'd6:          r = two_chars(7'h41, 7'h45);
            6'd7:          r = one_char(7'h43);
            [6'd8:6'd11]:  r = one_char(7'h45);
            [6'd12:6'd15]: r = one_char(7'h49);
            6'd16:         r = one_char(7'h44);
            6'd17:         r = one_char(7'h4E);
            [6'd18:6'd22]: r = one_char(7'h4F);
            6'd23:         r = one_char(7'h78);
            6'd24:         r = one_char(7'h4F);
            [6'd25:6'd28]: r = one_char(7'h55);
            6'd29:         r = one_char(7'h59);
            6'd30:         r = two_chars(7'h54, 7'h68);
            6'd31:         r = two_chars(7'h73, 7'h73);
            [6'd32:6'd37]: r = one_char(7'h61);
            6'd38:         r = two_chars(7'h61, 7'h65);
            6'd39:         r = one_char(7'h63);
            [6'd40:6'd43]: r = one_char(7'h65);
            [6'd44:6'd47]: r = one_char(7'h69);
            6'd48:         r = one_char(7'h64);
            6'd49:         r = one_char(7'h6E);
            [6'd50:6'd54]: r = one_char(7'h6F);
            6'd55:         r = one_char(7'h2F);
            6'd56:         r = one_char(7'h6F);
            [6'd57:6'd60]: r = one_char(7'h75);
            6'd61:         r = one_char(7'h79);
            6'd62:         r = two_chars(7'h74, 7'h68);
            default:       r = one_char(7'h79);
        endcase
        return r;
    endfunction

    function automatic dtsf_chars_t map_code_point(logic [20:0] cp);
        dtsf_chars_t r;
        if (cp < 21'h20 || cp == 21'h7F) begin
            r = one_char(CH_SPACE);
        end else if (cp < 21'h80) begin
            r = one_char(cp[6:0]);
        end else if (cp >= 21'hC0 && cp <= 21'hFF) begin
            r = fold_lookup(cp[5:0]);
        end else begin
            case (cp) inside
                21'h00A0, 21'h2002, 21'h2003, 21'h2009:
                    r = one_char(CH_SPACE);
                21'h00B4, 21'h2018, 21'h2019, 21'h201A, 21'h2032:
                    r = one_char(CH_QUOTE);
                21'h00AB, 21'h00BB, 21'h201C, 21'h201D, 21'h201E, 21'h2033:
                    r = one_char(CH_DQUOT);
                [21'h2010:21'h2015], 21'h2212:
                    r = one_char(CH_DASH);
                21'h2026: begin
                    r.cnt = 2'd3;
                    r.c0  = CH_DOT;
                    r.c1  = CH_DOT;
                    r.c2  = CH_DOT;
                end
                default:
                    r = one_char(CH_QMARK);
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] header_byte(logic [HDR_IDX_W-1:0] idx, logic [6:0] line);
        logic [7:0] b;
        case (idx)
            3'd0:    b = SYX_START;
            3'd1:    b = SYX_MFR;
            3'd2:    b = SYX_DEV;
            3'd3:    b = SYX_MODEL;
            3'd4:    b = SYX_CMD;
            default: b = {1'b0, line};
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/display_text_sysex_framer.sv -----
// Top level of the display text SysEx framer: front end, item queue and back end.
// Depends on dtsf_pkg, dtsf_front, dtsf_queue and dtsf_back.
//
//   Channel   Signals                              Moves
//   input     in_valid/in_ready, code_point,       one code point request
//             final_char
//   output    out_valid/out_ready, frame_byte,     one frame byte request
//             frame_end
//   config    cfg_wen, cfg_wdata                   display line number, no wait
//
// The back end takes one step a cycle, stalling only on a step that sends a byte while the
// output is held: the six header bytes on the first item of a frame, one step per mapped
// character (plus one per held space sent), and one closing step per item that also carries
// F7 on the last item.
// A four-entry queue lets the front accept items while the back is stalled.
// Reset clears all control state; no clearing pass is needed.
`default_nettype none

module display_text_sysex_framer
    import dtsf_pkg::*;
#(
    parameter int MAX_TEXT = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [20:0] code_point,
    input  wire logic        final_char,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       frame_byte,
    output logic             frame_end
);

    logic        q_full;
    logic        q_push;
    dtsf_entry_t q_data;
    logic        q_pop;
    dtsf_entry_t q_head;
    logic        q_not_empty;

    dtsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_point (code_point),
        .final_char (final_char),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    dtsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    dtsf_back #(
        .MAX_TEXT (MAX_TEXT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (q_head),
        .entry_valid (q_not_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

// ----- hdl/dtsf_front.sv -----
// Front end of the framer: accepts code points, maps them to display characters and
// marks the first item of each frame. Depends on dtsf_pkg.
`default_nettype none

module dtsf_front
    import dtsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [20:0] code_point,
    input  wire logic        final_char,
    input  wire logic        q_full,
    output logic             q_push,
    output dtsf_entry_t      q_data
);

    logic [6:0] display_line_reg;
    logic       header_sent_reg;
    logic       header_sent_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_data.hdr   = !header_sent_reg;
        q_data.line  = display_line_reg;
        q_data.chars = map_code_point(code_point);
        q_data.last  = final_char;
    end

    // The last item of a text closes the frame, so the next item opens a new one.
    assign header_sent_next = q_push ? !final_char : header_sent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            display_line_reg <= 7'd0;
            header_sent_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                display_line_reg <= cfg_wdata;
            end
            header_sent_reg <= header_sent_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dtsf_queue.sv -----
// Short FIFO of classified items between the front and back of the framer.
// Depends on dtsf_pkg.
`default_nettype none

module dtsf_queue
    import dtsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire dtsf_entry_t push_data,
    output logic            full,
    input  wire logic       pop,
    output dtsf_entry_t     head,
    output logic            not_empty
);

    dtsf_entry_t           slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;
    logic [QPTR_W:0]       count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dtsf_back.sv -----
// Back end of the framer: steps through one queued item, one step a cycle unless the output stalls,
// sending header, held spaces, characters and, on the last item, the closing byte. Depends on dtsf_pkg.
`default_nettype none

module dtsf_back
    import dtsf_pkg::*;
#(
    parameter int MAX_TEXT = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dtsf_entry_t entry,
    input  wire logic        entry_valid,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       frame_byte,
    output logic             frame_end
);

    localparam int KW = $clog2(MAX_TEXT + 1);

    logic [HDR_IDX_W-1:0] hdr_idx_reg,  hdr_idx_next;
    logic [1:0]           char_idx_reg, char_idx_next;
    logic                 text_begun_reg, text_begun_next;
    logic [KW-1:0]        kept_reg, kept_next;
    logic [KW-1:0]        held_reg, held_next;
    logic                 out_valid_reg;
    logic [7:0]           frame_byte_reg;
    logic                 frame_end_reg;

    logic                 slot_free;
    logic                 emit;
    logic                 go;
    logic                 done;
    logic [7:0]           emit_byte;
    logic                 emit_end;
    logic [6:0]           cur_ch;
    logic                 cur_space;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (char_idx_reg)
            2'd0:    cur_ch = entry.chars.c0;
            2'd1:    cur_ch = entry.chars.c1;
            default: cur_ch = entry.chars.c2;
        endcase
    end

    assign cur_space = (cur_ch == CH_SPACE);

    always_comb
    begin
        hdr_idx_next    = hdr_idx_reg;
        char_idx_next   = char_idx_reg;
        text_begun_next = text_begun_reg;
        kept_next       = kept_reg;
        held_next       = held_reg;
        emit            = 1'b0;
        emit_byte       = SYX_END;
        emit_end        = 1'b0;
        done            = 1'b0;
        if (entry_valid)
        begin
            if (entry.hdr && hdr_idx_reg < HDR_IDX_W'(HDR_LEN))
            begin
                emit         = 1'b1;
                emit_byte    = header_byte(hdr_idx_reg, entry.line);
                hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
            end
            else if (char_idx_reg < entry.chars.cnt)
            begin
                if (!text_begun_reg && cur_space)
                begin
                    // Leading spaces are dropped.
                    char_idx_next = char_idx_reg + 2'd1;
                end
                else if (kept_reg >= KW'(MAX_TEXT))
                begin
                    text_begun_next = 1'b1;
                    char_idx_next   = char_idx_reg + 2'd1;
                end
                else if (cur_space)
                begin
                    text_begun_next = 1'b1;
                    held_next       = held_reg + KW'(1);
                    kept_next       = kept_reg + KW'(1);
                    char_idx_next   = char_idx_reg + 2'd1;
                end
                else if (held_reg != '0)
                begin
                    // Held spaces go out one per cycle, while the output takes them, before the character.
                    text_begun_next = 1'b1;
                    emit            = 1'b1;
                    emit_byte       = {1'b0, CH_SPACE};
                    held_next       = held_reg - KW'(1);
                end
                else
                begin
                    text_begun_next = 1'b1;
                    emit            = 1'b1;
                    emit_byte       = {1'b0, cur_ch};
                    kept_next       = kept_reg + KW'(1);
                    char_idx_next   = char_idx_reg + 2'd1;
                end
            end
            else
            begin
                done          = 1'b1;
                hdr_idx_next  = '0;
                char_idx_next = 2'd0;
                if (entry.last)
                begin
                    emit            = 1'b1;
                    emit_byte       = SYX_END;
                    emit_end        = 1'b1;
                    text_begun_next = 1'b0;
                    kept_next       = '0;
                    held_next       = '0;
                end
            end
        end
    end

    assign go  = !emit || slot_free;
    assign pop = done && go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg    <= '0;
            char_idx_reg   <= 2'd0;
            text_begun_reg <= 1'b0;
            kept_reg       <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                hdr_idx_reg    <= hdr_idx_next;
                char_idx_reg   <= char_idx_next;
                text_begun_reg <= text_begun_next;
                kept_reg       <= kept_next;
                held_reg       <= held_next;
            end
            if (slot_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && emit)
        begin
            frame_byte_reg <= emit_byte;
            frame_end_reg  <= emit_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign frame_end  = frame_end_reg;

endmodule

`default_nettype wire

// ----- hdl/dtsf_checker.sv -----
// Port-level checker for the display text SysEx framer, with its bind statement.
// Depends on dtsf_pkg and display_text_sysex_framer.
`default_nettype none

module dtsf_checker
    import dtsf_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  frame_byte,
    input wire logic        frame_end
);

    logic expect_start_reg;
    logic out_take;

    assign out_take = out_valid && out_ready;

    // Set when the next byte taken has to open a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_start_reg <= 1'b1;
        end
        else if (out_take)
        begin
            expect_start_reg <= frame_end;
        end
    end

    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> frame_byte == SYX_END)
        else $error("frame_end set on a byte other than F7");

    a_status_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_byte[7] |-> frame_byte == SYX_START || frame_byte == SYX_END)
        else $error("status byte inside the frame body");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && expect_start_reg |-> frame_byte == SYX_START)
        else $error("frame does not open with F0");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(frame_end))
        else $error("stalled output byte changed");

endmodule

bind display_text_sysex_framer dtsf_checker u_dtsf_checker (.*);

`default_nettype wire
